>>> sv/msf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types and constants of the 3x3 majority smoothing filter.
// ----------------------------------------------------------------------------
package msf_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

  localparam int CFG_W = 11;
  localparam int THR_W = 4;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 4'd6;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = 2;
  localparam int OQ_CW    = 3;

  typedef logic [1:0] class_t;

  typedef enum logic {
    CMD_CELL  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t   command;
    class_t cell_class;
  } in_t;

  typedef struct packed {
    class_t smoothed_class;
    logic   frame_end;
  } out_t;

  // One line buffer entry: the column's cell two rows up and one row up
  typedef struct packed {
    class_t upper;
    class_t middle;
  } line_t;

endpackage

>>> sv/msf_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msf_out_fifo
// Small result queue that decouples the filter pipeline from the consumer.
// ----------------------------------------------------------------------------
module msf_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  msf_pkg::out_t                   push_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output msf_pkg::out_t                   out_data,
  output logic [msf_pkg::OQ_CW-1:0]       level
);

  msf_pkg::out_t                 q_mem [msf_pkg::OQ_DEPTH];
  logic [msf_pkg::OQ_PW-1:0]     wr_ptr_r;
  logic [msf_pkg::OQ_PW-1:0]     rd_ptr_r;
  logic [msf_pkg::OQ_CW-1:0]     count_r;
  logic                          pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign level     = count_r;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + msf_pkg::OQ_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + msf_pkg::OQ_PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + msf_pkg::OQ_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - msf_pkg::OQ_CW'(1);
      end
    end
  end

endmodule

>>> sv/majority_smoothing_filter_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// majority_smoothing_filter_3x3_core
// 3x3 mode filter over a raster stream of 2-bit cell classes, line buffers
// in one synchronous RAM, results through a small output queue.
// ----------------------------------------------------------------------------
//  channel | signals                       | payload
//  --------+-------------------------------+-------------------------------
//  input   | in_valid / in_ready / in_data | command, cell_class
//  result  | out_valid/out_ready/out_data  | smoothed_class, frame_end
//  config  | cfg_we / cfg_index / cfg_wdata| width, height, threshold
//
//  One cell per clock. A transfer goes through stage 1 and stage 2 into the
//  queue; results lag the cells by frame width plus one items.
//  in_ready drops only when the 4-entry result queue plus results in flight
//  would overflow, so a stalled consumer holds off the source after that.
//  Reset (synchronous, rst_n low) clears position, lag count, window and
//  queue; line buffer contents are don't-care until written.
// ----------------------------------------------------------------------------
module majority_smoothing_filter_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  msf_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output msf_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [msf_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = $clog2(MAX_WIDTH + 2);
  localparam int WXW = (WW > msf_pkg::CFG_W) ? WW : msf_pkg::CFG_W;
  localparam int HXW = (HW > msf_pkg::CFG_W) ? HW : msf_pkg::CFG_W;

  // Configuration
  logic [msf_pkg::CFG_W-1:0] frame_width_r;
  logic [msf_pkg::CFG_W-1:0] frame_height_r;
  logic [msf_pkg::THR_W-1:0] threshold_r;

  // Position and lag
  logic [CW-1:0] col_r,  col_nxt;
  logic [RW-1:0] row_r,  row_nxt;
  logic [PW-1:0] pend_r, pend_nxt;

  // Stage 1: line buffer read returns
  logic                   s1_val_r;
  logic                   s1_emit_r;
  msf_pkg::class_t        s1_v_r;
  logic [CW-1:0]          s1_col_r;
  logic                   s1_int_r;
  logic                   s1_last_r;
  msf_pkg::line_t         line_q_r;
  logic                   fwd_hit_r;
  msf_pkg::line_t         fwd_data_r;
  msf_pkg::line_t         line_eff;
  msf_pkg::line_t         s1_wr;

  // Stage 2: window evaluation
  logic                   s2_emit_r;
  logic                   s2_int_r;
  logic                   s2_last_r;
  logic [8:0][1:0]        win_r;

  msf_pkg::line_t         line_mem [MAX_WIDTH];

  logic [WXW-1:0]         fw_ext;
  logic [HXW-1:0]         fh_ext;
  logic [WW-1:0]          w_sz;
  logic [HW-1:0]          h_sz;
  logic [WW-1:0]          col_inc;
  logic [HW-1:0]          row_inc;
  logic [PW-1:0]          w_plus1;
  logic                   acc;
  logic                   is_flush;
  logic                   op;
  logic                   emit;
  msf_pkg::class_t        cell_v;
  logic                   interior;
  logic                   last_cell;

  logic [3:0]             cnt [4];
  logic [3:0]             best_cnt;
  msf_pkg::class_t        best_cls;
  msf_pkg::out_t          res;
  logic [msf_pkg::OQ_CW-1:0] q_level;
  logic [msf_pkg::OQ_CW-1:0] q_need;

  // Clamp frame size to [3, MAX]
  always_comb begin
    fw_ext = WXW'(frame_width_r);
    fh_ext = HXW'(frame_height_r);
    priority if (fw_ext < WXW'(3)) begin
      w_sz = WW'(3);
    end else if (fw_ext > WXW'(MAX_WIDTH)) begin
      w_sz = WW'(MAX_WIDTH);
    end else begin
      w_sz = fw_ext[WW-1:0];
    end
    priority if (fh_ext < HXW'(3)) begin
      h_sz = HW'(3);
    end else if (fh_ext > HXW'(MAX_HEIGHT)) begin
      h_sz = HW'(MAX_HEIGHT);
    end else begin
      h_sz = fh_ext[HW-1:0];
    end
  end

  // Accept when the queue has room for every result in flight
  assign q_need   = q_level + msf_pkg::OQ_CW'(s1_emit_r) + msf_pkg::OQ_CW'(s2_emit_r);
  assign in_ready = (q_need < msf_pkg::OQ_CW'(msf_pkg::OQ_DEPTH));
  assign acc      = in_valid && in_ready;

  // Decode the accepted item
  always_comb begin
    is_flush  = (in_data.command == msf_pkg::CMD_FLUSH);
    w_plus1   = PW'(w_sz) + PW'(1);
    op        = !is_flush || (pend_r != '0);
    emit      = is_flush ? (pend_r != '0) : (pend_r >= w_plus1);
    cell_v    = is_flush ? msf_pkg::class_t'(0) : in_data.cell_class;
    col_inc   = WW'(col_r) + WW'(1);
    row_inc   = HW'(row_r) + HW'(1);
    interior  = (WW'(col_r) >= WW'(2)) && (WW'(col_r) < w_sz) &&
                (HW'(row_r) >= HW'(2)) && (HW'(row_r) < h_sz);
    last_cell = (col_r == '0) && (row_r == RW'(1));
  end

  // Next position and lag count
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (acc && op) begin
      if (col_inc >= w_sz) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_sz) ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
      if (is_flush) begin
        pend_nxt = pend_r - PW'(1);
        if (pend_r == PW'(1)) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end else if (!emit) begin
        pend_nxt = pend_r + PW'(1);
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= msf_pkg::FRAME_WIDTH_RST;
      frame_height_r <= msf_pkg::FRAME_HEIGHT_RST;
      threshold_r    <= msf_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msf_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        msf_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        msf_pkg::CFG_THRESHOLD:    threshold_r    <= cfg_wdata[msf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold position and lag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Line buffer RAM: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      line_q_r <= line_mem[col_r];
    end
    if (s1_val_r) begin
      line_mem[s1_col_r] <= s1_wr;
    end
  end

  // Forward the write of the previous item when it hits the same column
  assign line_eff = fwd_hit_r ? fwd_data_r : line_q_r;
  assign s1_wr    = '{upper: line_eff.middle, middle: s1_v_r};

  always_ff @(posedge clk) begin
    fwd_data_r <= s1_wr;
    s1_v_r     <= cell_v;
    s1_col_r   <= col_r;
    s1_int_r   <= interior;
    s1_last_r  <= last_cell;
    s2_int_r   <= s1_int_r;
    s2_last_r  <= s1_last_r;
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_val_r  <= 1'b0;
      s1_emit_r <= 1'b0;
      fwd_hit_r <= 1'b0;
      s2_emit_r <= 1'b0;
    end else begin
      s1_val_r  <= acc && op;
      s1_emit_r <= acc && emit;
      fwd_hit_r <= acc && s1_val_r && (s1_col_r == col_r);
      s2_emit_r <= s1_emit_r;
    end
  end

  // Shift the new column into the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_val_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3 + 1];
        win_r[r*3 + 1] <= win_r[r*3 + 2];
      end
      win_r[2] <= line_eff.upper;
      win_r[5] <= line_eff.middle;
      win_r[8] <= s1_v_r;
    end
  end

  // Count classes in the window, pick the most frequent (lowest on a tie)
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt[k] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      cnt[win_r[i]] = cnt[win_r[i]] + 4'd1;
    end
    best_cnt = '0;
    best_cls = '0;
    for (int k = 0; k < 4; k++) begin
      if (cnt[k] > best_cnt) begin
        best_cnt = cnt[k];
        best_cls = msf_pkg::class_t'(k);
      end
    end
    res.frame_end = s2_last_r;
    if (s2_int_r && (best_cnt >= threshold_r)) begin
      res.smoothed_class = best_cls;
    end else begin
      res.smoothed_class = win_r[4];
    end
  end

  msf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_emit_r),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .level     (q_level)
  );

endmodule
